// ===== sv/non_crossing_segment_filter_macros.svh =====
// Assertion macros for the non-crossing segment filter checker.
// Each macro takes a label, clock, active-low reset, terms and a message string.
`ifndef NON_CROSSING_SEGMENT_FILTER_MACROS_SVH
`define NON_CROSSING_SEGMENT_FILTER_MACROS_SVH

// same-cycle implication
`define NSF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nsf_pkg.sv =====
// Shared types and constants of the non-crossing segment filter.
// No dependencies; imported by every module of the block except nsf_ram.
package nsf_pkg;

  localparam int FIELD_W   = 16;
  localparam int RAW_W     = 32;
  localparam int LIMIT_W   = 7;
  localparam int COUNT_O_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_CROSSING = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef struct packed {
    logic                       command;
    logic signed [FIELD_W-1:0]  start_x;
    logic signed [FIELD_W-1:0]  start_y;
    logic signed [FIELD_W-1:0]  end_x;
    logic signed [FIELD_W-1:0]  end_y;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [COUNT_O_W-1:0]   stored_count;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } cross_status_t;

endpackage

// ===== sv/nsf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module nsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== sv/nsf_cross.sv =====
// Pipelined segment crossing test: differences, products, orientation compare.
// Depends on nsf_pkg for the status struct.
module nsf_cross
  import nsf_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [4*COORD_WIDTH-1:0]   cand_i,
  input  logic                       entry_valid_i,
  input  logic [4*COORD_WIDTH-1:0]   entry_i,
  output cross_status_t              status_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = cand_i[4*CW-1:3*CW];
  assign ay = cand_i[3*CW-1:2*CW];
  assign bx = cand_i[2*CW-1:CW];
  assign by = cand_i[CW-1:0];
  assign cx = entry_i[4*CW-1:3*CW];
  assign cy = entry_i[3*CW-1:2*CW];
  assign dx = entry_i[2*CW-1:CW];
  assign dy = entry_i[CW-1:0];

  function automatic logic signed [DW-1:0] diff(logic signed [CW-1:0] p,
                                                logic signed [CW-1:0] q);
    return $signed({p[CW-1], p}) - $signed({q[CW-1], q});
  endfunction

  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] cxa_q, cya_q, dxa_q, dya_q, cxb_q, cyb_q, dxb_q, dyb_q;
  logic signed [DW-1:0] bax_q, bay_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q;
  logic                 hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= entry_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_valid_i) begin
      cxa_q <= diff(cx, ax);
      cya_q <= diff(cy, ay);
      dxa_q <= diff(dx, ax);
      dya_q <= diff(dy, ay);
      cxb_q <= diff(cx, bx);
      cyb_q <= diff(cy, by);
      dxb_q <= diff(dx, bx);
      dyb_q <= diff(dy, by);
      bax_q <= diff(bx, ax);
      bay_q <= diff(by, ay);
    end
    if (v1_q) begin
      p1a_q <= dya_q * cxa_q;
      p1b_q <= cya_q * dxa_q;
      p2a_q <= dyb_q * cxb_q;
      p2b_q <= cyb_q * dxb_q;
      p3a_q <= cya_q * bax_q;
      p3b_q <= bay_q * cxa_q;
      p4a_q <= dya_q * bax_q;
      p4b_q <= bay_q * dxa_q;
    end
    if (v2_q) begin
      hit_q <= ((p1a_q > p1b_q) != (p2a_q > p2b_q)) &&
               ((p3a_q > p3b_q) != (p4a_q > p4b_q));
    end
  end

  assign status_o.valid = v3_q;
  assign status_o.hit   = hit_q;
  assign status_o.busy  = v1_q | v2_q | v3_q;

endmodule

// ===== sv/non_crossing_segment_filter.sv =====
// Non-crossing segment filter: table of segments, each offer checked against the stored entries.
// An offer is scanned against the stored segments and stops early on a crossing; a clear
// or an offer to a full table skips the scan.
// One transaction at a time: the next is taken once the result has posted.
// Reset: count cleared, limit set to 64; table contents stay undefined until written.
// Depends on nsf_pkg, nsf_ram and nsf_cross.
module non_crossing_segment_filter
  import nsf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     count_q, idx_q, count_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 hit_q, full_q, clear_q, rd_valid_q, out_valid_q;
  out_item_t            out_data_q;
  logic [4*CW-1:0]      cand_q, cand_d, rd_data;
  logic [CMP_W-1:0]     cap, count_ext, stored_ext;
  logic                 issue, out_free, wr_en, hit_now;
  status_e              status_d;
  cross_status_t        xs;
  logic [RAW_W-1:0]     raw_sx, raw_sy, raw_ex, raw_ey;

  assign raw_sx = {{(RAW_W-FIELD_W){1'b0}}, in_data_i.start_x};
  assign raw_sy = {{(RAW_W-FIELD_W){1'b0}}, in_data_i.start_y};
  assign raw_ex = {{(RAW_W-FIELD_W){1'b0}}, in_data_i.end_x};
  assign raw_ey = {{(RAW_W-FIELD_W){1'b0}}, in_data_i.end_y};
  assign cand_d = {raw_sx[CW-1:0], raw_sy[CW-1:0], raw_ex[CW-1:0], raw_ey[CW-1:0]};

  assign count_ext = CMP_W'(count_q);
  assign cap = (CMP_W'(limit_q) < CMP_W'(TABLE_DEPTH)) ? CMP_W'(limit_q)
                                                       : CMP_W'(TABLE_DEPTH);

  assign hit_now  = xs.valid && xs.hit;
  assign issue    = (state_q == S_SCAN) && (idx_q < count_q) && !hit_q && !hit_now;
  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_en    = (state_q == S_FINISH) && out_free && !clear_q && !full_q && !hit_q;

  always_comb begin
    count_d  = count_q;
    status_d = ST_ACCEPTED;
    if (clear_q) begin
      count_d  = '0;
      status_d = ST_CLEARED;
    end else if (full_q) begin
      status_d = ST_FULL;
    end else if (hit_q) begin
      status_d = ST_CROSSING;
    end else begin
      count_d  = CNT_W'(count_q + 1'b1);
    end
  end

  assign stored_ext = CMP_W'(count_d);

  nsf_ram #(
    .WIDTH (4 * CW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (cand_q),
    .rd_en_i   (issue),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  nsf_cross #(
    .COORD_WIDTH (CW)
  ) u_cross (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cand_i        (cand_q),
    .entry_valid_i (rd_valid_q),
    .entry_i       (rd_data),
    .status_o      (xs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      limit_q     <= LIMIT_RESET;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
      clear_q     <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      rd_valid_q <= issue;
      if (hit_now) begin
        hit_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cand_q  <= cand_d;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            clear_q <= (in_data_i.command == CMD_CLEAR);
            full_q  <= (count_ext >= cap);
            if (in_data_i.command == CMD_CLEAR || count_ext >= cap) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            idx_q <= CNT_W'(idx_q + 1'b1);
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid_q && !xs.busy) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_data_q.status       <= status_d;
            out_data_q.stored_count <= stored_ext[COUNT_O_W-1:0];
            count_q                 <= count_d;
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/nsf_checker.sv =====
// Port-level checker for the non-crossing segment filter, bound to the top level.
// Depends on nsf_pkg and non_crossing_segment_filter_macros.svh.
`include "non_crossing_segment_filter_macros.svh"

module nsf_checker
  import nsf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_item_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [LIMIT_W-1:0] cfg_data_i
);

  `NSF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result transaction changed")
  `NSF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken again right after a transaction")
  `NSF_ASSERT_IMP(a_no_cfg_when_busy, clk_i, rst_ni, in_stall_o, !cfg_ready_o, "configuration ready while a transaction is in work")
  `NSF_ASSERT_IMP(a_clear_empties, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_CLEARED, out_data_o.stored_count == '0, "clear reported a nonzero count")

endmodule

bind non_crossing_segment_filter nsf_checker u_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for non_crossing_segment_filter: checks every result against a
// built-in predictor of the segment table and its limit register, under random idling.
// Depends on nsf_pkg and the non_crossing_segment_filter RTL only.
`timescale 1ns / 1ps

module testbench;
  import nsf_pkg::*;

  localparam int TABLE_DEPTH = 64;

  typedef struct {
    longint sx;
    longint sy;
    longint ex;
    longint ey;
  } kept_seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  in_item_t pending_items[$];
  out_item_t expected_outcomes[$];
  in_item_t recent_offers[$];

  kept_seg_t kept_segs[TABLE_DEPTH];
  int kept_count = 0;
  logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

  bit item_taken = 1'b0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int in_gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int items_taken = 0;
  int limit_writes = 0;
  int peak_count = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  non_crossing_segment_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch in %s at %0t ns: got %0d, expected %0d", what, $time, got, want);
  endtask

  function automatic bit turns_left(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    return (ry - py) * (qx - px) > (qy - py) * (rx - px);
  endfunction

  function automatic bit cuts_entry(longint ax, longint ay, longint bx, longint by, int k);
    bit t1, t2, t3, t4;
    t1 = turns_left(ax, ay, kept_segs[k].sx, kept_segs[k].sy, kept_segs[k].ex, kept_segs[k].ey);
    t2 = turns_left(bx, by, kept_segs[k].sx, kept_segs[k].sy, kept_segs[k].ex, kept_segs[k].ey);
    t3 = turns_left(ax, ay, bx, by, kept_segs[k].sx, kept_segs[k].sy);
    t4 = turns_left(ax, ay, bx, by, kept_segs[k].ex, kept_segs[k].ey);
    return (t1 != t2) && (t3 != t4);
  endfunction

  function automatic out_item_t predict_outcome(in_item_t it);
    out_item_t res;
    int cap;
    bit hit;
    longint ax, ay, bx, by;
    cap = (int'(limit_now) < TABLE_DEPTH) ? int'(limit_now) : TABLE_DEPTH;
    ax = longint'($signed(it.start_x));
    ay = longint'($signed(it.start_y));
    bx = longint'($signed(it.end_x));
    by = longint'($signed(it.end_y));
    hit = 1'b0;
    if (it.command == CMD_CLEAR) begin
      kept_count = 0;
      res.status = ST_CLEARED;
    end else if (kept_count >= cap) begin
      res.status = ST_FULL;
    end else begin
      for (int k = 0; k < kept_count; k++) begin
        if (!hit && cuts_entry(ax, ay, bx, by, k)) hit = 1'b1;
      end
      if (hit) begin
        res.status = ST_CROSSING;
      end else begin
        kept_segs[kept_count] = '{ax, ay, bx, by};
        kept_count++;
        res.status = ST_ACCEPTED;
      end
    end
    res.stored_count = COUNT_O_W'(kept_count);
    return res;
  endfunction

  function automatic int draw_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clip16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return FIELD_W'(v);
  endfunction

  function automatic int coord(logic signed [FIELD_W-1:0] c);
    return int'($signed(c));
  endfunction

  function automatic in_item_t offer(int sx, int sy, int ex, int ey);
    in_item_t it;
    it.command = CMD_OFFER;
    it.start_x = clip16(sx);
    it.start_y = clip16(sy);
    it.end_x = clip16(ex);
    it.end_y = clip16(ey);
    return it;
  endfunction

  function automatic in_item_t clear_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.command = CMD_CLEAR;
    return it;
  endfunction

  function automatic in_item_t short_segment();
    int cx, cy;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    return offer(cx, cy, cx + int'($urandom_range(0, 3000)) - 1500,
                 cy + int'($urandom_range(0, 3000)) - 1500);
  endfunction

  function automatic in_item_t crossing_of(in_item_t s);
    int mx, my, dx, dy;
    mx = (coord(s.start_x) + coord(s.end_x)) / 2;
    my = (coord(s.start_y) + coord(s.end_y)) / 2;
    dx = coord(s.end_x) - coord(s.start_x);
    dy = coord(s.end_y) - coord(s.start_y);
    return offer(mx + dy, my - dx, mx - dy, my + dx);
  endfunction

  function automatic in_item_t touching_of(in_item_t s);
    int sx, sy, ex, ey;
    sx = coord(s.start_x);
    sy = coord(s.start_y);
    ex = coord(s.end_x);
    ey = coord(s.end_y);
    case ($urandom_range(0, 2))
      0: return offer(ex, ey, ex + int'($urandom_range(0, 800)) - 400,
                      ey + int'($urandom_range(0, 800)) - 400);
      1: return offer(ex, ey, 2 * ex - sx, 2 * ey - sy);
      default: return offer(sx, sy, ex, ey);
    endcase
  endfunction

  function automatic int wild_coord();
    int extremes[5] = '{-32768, -1, 0, 1, 32767};
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return extremes[$urandom_range(0, 4)];
  endfunction

  function automatic in_item_t wild_segment();
    return offer(wild_coord(), wild_coord(), wild_coord(), wild_coord());
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_now = v;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items,
                           input int clear_pct);
    int pick;
    in_item_t it;
    in_gaps_on = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    write_limit(lim);
    pending_items.push_back(clear_item());
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) it = clear_item();
      else if (pick < 55) it = short_segment();
      else if (pick < 72 && recent_offers.size() > 0)
        it = crossing_of(recent_offers[$urandom_range(0, recent_offers.size() - 1)]);
      else if (pick < 82 && recent_offers.size() > 0)
        it = touching_of(recent_offers[$urandom_range(0, recent_offers.size() - 1)]);
      else if (pick < 95) it = wild_segment();
      else begin
        it = short_segment();
        it.end_x = it.start_x;
        it.end_y = it.start_y;
      end
      if (it.command == CMD_OFFER) begin
        recent_offers.push_back(it);
        if (recent_offers.size() > 16) recent_offers.delete(0);
      end
      pending_items.push_back(it);
    end
    wait_idle();
  endtask

  // drive input transactions
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        item_taken = 1'b0;
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items.pop_front();
          in_gap_left = draw_gap(in_gaps_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = draw_gap(out_stalls_on);
      out_stall_i <= 1'b0;
    end
  end

  // predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        items_taken++;
        expected_outcomes.push_back(predict_outcome(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result status", int'(out_data_o.status), -1);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", int'(out_data_o.status), int'(want.status));
          if (out_data_o.stored_count !== want.stored_count)
            report_mismatch("stored_count", int'(out_data_o.stored_count),
                            int'(want.stored_count));
          status_seen[int'(want.status)]++;
          if (int'(want.stored_count) > peak_count) peak_count = int'(want.stored_count);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    pending_items.push_back(offer(-1, -1, -1, -1));
    pending_items[0].command = CMD_CLEAR;
    pending_items.push_back(offer(-32768, -32768, 32767, 32767));
    pending_items.push_back(offer(-32768, 32767, 32767, -32768));
    pending_items.push_back(offer(-32768, -32768, 0, 0));
    pending_items.push_back(offer(0, 0, 0, 0));
    pending_items.push_back(offer(100, -200, 100, 200));
    pending_items.push_back(offer(200, 200, 400, 0));
    pending_items.push_back(offer(0, 1000, 1000, 2000));
    pending_items.push_back(offer(32767, -32768, 32767, -32768));
    pending_items.push_back(offer(-32768, 0, 32767, 0));
    pending_items.push_back(offer(32767, 32767, 32767, -32768));
    pending_items.push_back(clear_item());
    pending_items.push_back(offer(0, -32768, 0, 32767));
    pending_items.push_back(offer(-32768, 5, 32767, 5));
    wait_idle();

    run_phase(7'd0, 30, 5);
    run_phase(7'd1, 50, 8);
    run_phase(7'd127, 200, 1);
    run_phase(LIMIT_W'($urandom_range(2, 63)), 110, 4);
    run_phase(7'd64, 180, 1);
    run_phase(7'd3, 50, 10);
    run_phase(7'd127, 120, 2);

    repeat (80) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      report_mismatch("results outstanding", 0, expected_outcomes.size());
    $display("ran %0d transactions over %0d limit writes: %0d accepted, %0d crossing, %0d full, %0d cleared",
             items_taken, limit_writes, status_seen[ST_ACCEPTED], status_seen[ST_CROSSING],
             status_seen[ST_FULL], status_seen[ST_CLEARED]);
    $display("largest table held: %0d segments, %0d mismatches", peak_count, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
